// ===== rtl/core/phm_pkg.sv =====
package phm_pkg;

   // counter store
   localparam int COUNT_W = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

   // default grid capacity
   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 128;

   // arithmetic widths
   localparam int COORD_W = 32;
   localparam int RECIP_W = 25;
   localparam int PROD_W  = COORD_W + RECIP_W;
   localparam int CELLS_W = PROD_W - 32;
   localparam int GRID_W  = CELLS_W + 1;
   localparam int IDX_W   = CELLS_W + 2;
   localparam int NUM_W   = 31;
   localparam int QUO_W   = 7;

   // register map (word index)
   localparam logic [2:0] REG_X_LOWER = 3'd0;
   localparam logic [2:0] REG_X_UPPER = 3'd1;
   localparam logic [2:0] REG_Y_LOWER = 3'd2;
   localparam logic [2:0] REG_Y_UPPER = 3'd3;
   localparam logic [2:0] REG_RECIP   = 3'd4;

   localparam logic [COORD_W-1:0] RST_X_LOWER = 32'hFFF60000;
   localparam logic [COORD_W-1:0] RST_X_UPPER = 32'h000A0000;
   localparam logic [COORD_W-1:0] RST_Y_LOWER = 32'hFFF60000;
   localparam logic [COORD_W-1:0] RST_Y_UPPER = 32'h000A0000;
   localparam logic [RECIP_W-1:0] RST_RECIP   = 25'h0050000;

   // commands
   localparam logic CMD_POSE = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // normalized cell codes
   localparam logic [7:0] CELL_UNSEEN = 8'hFF;
   localparam logic [7:0] CELL_FLOOR  = 8'd0;
   localparam logic [7:0] CELL_FULL   = 8'd100;
   localparam logic [6:0] CELL_SCALE  = 7'd100;

endpackage

// ===== rtl/core/pose_presence_heatmap_core.sv =====
// Channel   Dir  Handshake              Word
// req       in   req_valid / req_stall  cmd, pos_x, pos_y, last_pose, read_col, read_row
// rsp       out  rsp_valid / rsp_stall  cell_value, pose_binned, min_count, max_count
// csr       in   APB (psel..pready)     five box / reciprocal registers
//
// One word at a time. For a counted pose the result is loaded after 6 products on the shared
// 32x25 multiplier, the bin and the count read-modify-write; a read does the count read instead.
// A dropped pose or a read outside the active grid skips the count access. A last pose adds a
// scan over the active grid, one count store read per cell, skipped when the grid is empty.
// A read may add a division. The next word is taken in the cycle after the load.
// After reset a clearing pass writes zeros to all MAX_COLS*MAX_ROWS counts; req_stall is high.
// A finished word waits in the output register while the next word is accepted.
module pose_presence_heatmap_core #(
   parameter int MAX_COLS = phm_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = phm_pkg::DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic               req_last_pose,
   input  logic [6:0]         req_read_col,
   input  logic [6:0]         req_read_row,
   // response
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [7:0]  rsp_cell_value,
   output logic               rsp_pose_binned,
   output logic [23:0]        rsp_min_count,
   output logic [23:0]        rsp_max_count,
   // configuration
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int WW    = $clog2(MAX_COLS + 1);
   localparam int HW    = $clog2(MAX_ROWS + 1);

   localparam int CNT_W = phm_pkg::COUNT_W;
   localparam int GW    = phm_pkg::GRID_W;
   localparam int IW    = phm_pkg::IDX_W;
   localparam int NW    = phm_pkg::NUM_W;
   localparam int QW    = phm_pkg::QUO_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MUL, ST_EVAL, ST_POSE_WR, ST_SCAN_INIT,
      ST_SCAN, ST_SCAN_END, ST_READ_WAIT, ST_DIV, ST_DONE
   } st_type;

   // configuration registers
   logic signed [31:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   logic [phm_pkg::RECIP_W-1:0] recip_ff;
   logic csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_lo_ff  <= phm_pkg::RST_X_LOWER;
         x_hi_ff  <= phm_pkg::RST_X_UPPER;
         y_lo_ff  <= phm_pkg::RST_Y_LOWER;
         y_hi_ff  <= phm_pkg::RST_Y_UPPER;
         recip_ff <= phm_pkg::RST_RECIP;
      end else if (csr_wr) begin
         unique case (paddr[4:2])
            phm_pkg::REG_X_LOWER: x_lo_ff  <= pwdata;
            phm_pkg::REG_X_UPPER: x_hi_ff  <= pwdata;
            phm_pkg::REG_Y_LOWER: y_lo_ff  <= pwdata;
            phm_pkg::REG_Y_UPPER: y_hi_ff  <= pwdata;
            phm_pkg::REG_RECIP:   recip_ff <= pwdata[phm_pkg::RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (paddr[4:2])
         phm_pkg::REG_X_LOWER: prdata = x_lo_ff;
         phm_pkg::REG_X_UPPER: prdata = x_hi_ff;
         phm_pkg::REG_Y_LOWER: prdata = y_lo_ff;
         phm_pkg::REG_Y_UPPER: prdata = y_hi_ff;
         phm_pkg::REG_RECIP:   prdata = 32'(recip_ff);
         default:              prdata = '0;
      endcase
   end

   // control and item state
   st_type state_ff;
   logic [2:0] step_ff;
   logic [AW-1:0] clr_ff;
   logic cmd_ff, last_ff;
   logic signed [31:0] px_ff, py_ff;
   logic [6:0] col_ff, row_ff;

   // per-axis cell counts
   logic [phm_pkg::CELLS_W-1:0] cxl_ff, cxh_ff, cyl_ff, cyh_ff, tx_ff, ty_ff;
   logic [phm_pkg::PROD_W-1:0] prod_ff;

   logic [AW-1:0] addr_ff;
   logic binned_ff;
   logic [7:0] cell_ff;
   logic [CNT_W-1:0] smin_ff, smax_ff, mn_ff, mx_ff;

   // scan sequencer
   logic [CW-1:0] scol_ff;
   logic [RW-1:0] srow_ff;
   logic issue_ff, rd_vld_ff, rd_last_ff;

   // divider
   logic [NW-1:0] num_ff;
   logic [CNT_W-1:0] den_ff;
   logic [QW-1:0] quo_ff;
   logic [2:0] div_k_ff;

   // response register
   logic rsp_valid_ff, rsp_binned_ff;
   logic [7:0] rsp_cell_ff;
   logic [CNT_W-1:0] rsp_min_ff, rsp_max_ff;

   // count store
   logic ram_wr_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [CNT_W-1:0] ram_wr_data, ram_rd_data;

   phm_count_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared multiplier: |operand| * recip
   logic signed [31:0] mul_op;
   logic [31:0] mul_mag;
   logic [phm_pkg::PROD_W-1:0] prod_c;
   logic [phm_pkg::CELLS_W-1:0] ceil_c, trunc_c;

   always_comb begin
      case (step_ff)
         3'd0:    mul_op = x_lo_ff;
         3'd1:    mul_op = x_hi_ff;
         3'd2:    mul_op = y_lo_ff;
         3'd3:    mul_op = y_hi_ff;
         3'd4:    mul_op = px_ff;
         default: mul_op = py_ff;
      endcase
      mul_mag = mul_op[31] ? 32'(-mul_op) : 32'(mul_op);
      prod_c  = phm_pkg::PROD_W'(mul_mag) * phm_pkg::PROD_W'(recip_ff);
   end

   assign trunc_c = prod_ff[phm_pkg::PROD_W-1:32];
   assign ceil_c  = trunc_c + phm_pkg::CELLS_W'(|prod_ff[31:0]);

   // grid size and active extent
   logic [GW-1:0] gx_c, gy_c;
   logic [WW-1:0] w_c;
   logic [HW-1:0] h_c;

   assign gx_c = GW'(cxl_ff) + GW'(cxh_ff);
   assign gy_c = GW'(cyl_ff) + GW'(cyh_ff);
   assign w_c  = (gx_c < GW'(MAX_COLS)) ? WW'(gx_c) : WW'(MAX_COLS);
   assign h_c  = (gy_c < GW'(MAX_ROWS)) ? HW'(gy_c) : HW'(MAX_ROWS);

   // binning per axis, clamp on the upper edge
   logic signed [IW-1:0] ix_raw, iy_raw, ix, iy;
   logic in_box, x_ok, y_ok;

   always_comb begin
      ix_raw = (px_ff[31] ? -$signed({2'b00, tx_ff}) : $signed({2'b00, tx_ff}))
               + $signed({2'b00, cxl_ff});
      iy_raw = (py_ff[31] ? -$signed({2'b00, ty_ff}) : $signed({2'b00, ty_ff}))
               + $signed({2'b00, cyl_ff});
      ix = (ix_raw == $signed({1'b0, gx_c})) ? ix_raw - IW'(1) : ix_raw;
      iy = (iy_raw == $signed({1'b0, gy_c})) ? iy_raw - IW'(1) : iy_raw;
      x_ok = !ix[IW-1] && (ix < $signed(IW'(w_c)));
      y_ok = !iy[IW-1] && (iy < $signed(IW'(h_c)));
      in_box = (px_ff >= x_lo_ff) && (px_ff <= x_hi_ff) &&
               (py_ff >= y_lo_ff) && (py_ff <= y_hi_ff);
   end

   // store addresses
   logic [AW-1:0] pose_addr_c, read_addr_c, scan_addr_c;
   logic read_in_c, scan_last_c;

   assign pose_addr_c = AW'(AW'(iy[RW-1:0]) * AW'(MAX_ROWS == 0 ? 0 : MAX_COLS))
                        + AW'(ix[CW-1:0]);
   assign read_addr_c = AW'(AW'(row_ff) * AW'(MAX_COLS)) + AW'(col_ff);
   assign scan_addr_c = AW'(AW'(srow_ff) * AW'(MAX_COLS)) + AW'(scol_ff);
   assign read_in_c   = (col_ff < w_c) && (row_ff < h_c);
   assign scan_last_c = (WW'(scol_ff) == w_c - WW'(1)) && (HW'(srow_ff) == h_c - HW'(1));

   always_comb begin
      ram_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_POSE_WR);
      ram_wr_addr = (state_ff == ST_CLEAR) ? clr_ff : addr_ff;
      if (state_ff == ST_CLEAR) begin
         ram_wr_data = '0;
      end else if (ram_rd_data == phm_pkg::COUNT_MAX) begin
         ram_wr_data = ram_rd_data;
      end else begin
         ram_wr_data = ram_rd_data + CNT_W'(1);
      end
      if (state_ff == ST_SCAN) begin
         ram_rd_addr = scan_addr_c;
      end else if (cmd_ff == phm_pkg::CMD_READ) begin
         ram_rd_addr = read_addr_c;
      end else begin
         ram_rd_addr = pose_addr_c;
      end
   end

   // divider step and normalization numerator
   logic [NW-1:0] div_sub_c, num_c;
   logic div_take_c;
   logic [QW-1:0] quo_c;

   always_comb begin
      div_sub_c  = NW'(den_ff) << div_k_ff;
      div_take_c = (num_ff >= div_sub_c);
      quo_c      = quo_ff;
      if (div_take_c) begin
         quo_c[div_k_ff] = 1'b1;
      end
      num_c = NW'(ram_rd_data - smin_ff) * NW'(phm_pkg::CELL_SCALE);
   end

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer
   always_ff @(posedge clock) begin
      prod_ff <= prod_c;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         issue_ff     <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         smin_ff      <= '0;
         smax_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == AW'(DEPTH - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_cmd;
                  px_ff    <= req_pos_x;
                  py_ff    <= req_pos_y;
                  last_ff  <= req_last_pose;
                  col_ff   <= req_read_col;
                  row_ff   <= req_read_row;
                  step_ff  <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               // product of the previous step lands in its slot
               case (step_ff)
                  3'd1:    cxl_ff <= ceil_c;
                  3'd2:    cxh_ff <= ceil_c;
                  3'd3:    cyl_ff <= ceil_c;
                  3'd4:    cyh_ff <= ceil_c;
                  3'd5:    tx_ff  <= trunc_c;
                  3'd6:    ty_ff  <= trunc_c;
                  default: ;
               endcase
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd6) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               addr_ff <= ram_rd_addr;
               if (cmd_ff == phm_pkg::CMD_POSE) begin
                  cell_ff <= phm_pkg::CELL_FLOOR;
                  if (in_box && x_ok && y_ok) begin
                     binned_ff <= 1'b1;
                     state_ff  <= ST_POSE_WR;
                  end else begin
                     binned_ff <= 1'b0;
                     state_ff  <= last_ff ? ST_SCAN_INIT : ST_DONE;
                  end
               end else begin
                  binned_ff <= 1'b0;
                  if (read_in_c) begin
                     state_ff <= ST_READ_WAIT;
                  end else begin
                     cell_ff  <= phm_pkg::CELL_UNSEEN;
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_POSE_WR: begin
               state_ff <= last_ff ? ST_SCAN_INIT : ST_DONE;
            end
            ST_SCAN_INIT: begin
               rd_vld_ff  <= 1'b0;
               rd_last_ff <= 1'b0;
               if (w_c == '0 || h_c == '0) begin
                  smin_ff  <= '0;
                  smax_ff  <= '0;
                  state_ff <= ST_DONE;
               end else begin
                  scol_ff  <= '0;
                  srow_ff  <= '0;
                  issue_ff <= 1'b1;
                  mn_ff    <= phm_pkg::COUNT_MAX;
                  mx_ff    <= '0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // issue one read a cycle, fold the word from the cycle before
               if (issue_ff) begin
                  if (WW'(scol_ff) == w_c - WW'(1)) begin
                     scol_ff <= '0;
                     srow_ff <= srow_ff + RW'(1);
                  end else begin
                     scol_ff <= scol_ff + CW'(1);
                  end
                  if (scan_last_c) begin
                     issue_ff <= 1'b0;
                  end
               end
               rd_vld_ff  <= issue_ff;
               rd_last_ff <= issue_ff && scan_last_c;
               if (rd_vld_ff) begin
                  if (ram_rd_data < mn_ff) begin
                     mn_ff <= ram_rd_data;
                  end
                  if (ram_rd_data > mx_ff) begin
                     mx_ff <= ram_rd_data;
                  end
               end
               if (rd_last_ff) begin
                  state_ff <= ST_SCAN_END;
               end
            end
            ST_SCAN_END: begin
               smin_ff  <= mn_ff;
               smax_ff  <= mx_ff;
               state_ff <= ST_DONE;
            end
            ST_READ_WAIT: begin
               if (ram_rd_data == '0) begin
                  cell_ff  <= phm_pkg::CELL_UNSEEN;
                  state_ff <= ST_DONE;
               end else if (smax_ff <= smin_ff || ram_rd_data <= smin_ff) begin
                  cell_ff  <= phm_pkg::CELL_FLOOR;
                  state_ff <= ST_DONE;
               end else if (ram_rd_data >= smax_ff) begin
                  cell_ff  <= phm_pkg::CELL_FULL;
                  state_ff <= ST_DONE;
               end else begin
                  num_ff   <= num_c;
                  den_ff   <= smax_ff - smin_ff;
                  quo_ff   <= '0;
                  div_k_ff <= 3'(QW - 1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               // restoring division, one quotient bit a cycle
               if (div_take_c) begin
                  num_ff <= num_ff - div_sub_c;
               end
               quo_ff   <= quo_c;
               div_k_ff <= div_k_ff - 3'd1;
               if (div_k_ff == 3'd0) begin
                  cell_ff  <= {1'b0, quo_c};
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_cell_ff   <= cell_ff;
                  rsp_binned_ff <= binned_ff;
                  rsp_min_ff    <= smin_ff;
                  rsp_max_ff    <= smax_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_value  = $signed(rsp_cell_ff);
   assign rsp_pose_binned = rsp_binned_ff;
   assign rsp_min_count   = rsp_min_ff;
   assign rsp_max_count   = rsp_max_ff;

endmodule

// ===== rtl/core/phm_count_ram.sv =====
module phm_count_ram #(
   parameter int DEPTH = phm_pkg::DEF_MAX_COLS * phm_pkg::DEF_MAX_ROWS,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [phm_pkg::COUNT_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [phm_pkg::COUNT_W-1:0] rd_data
);

   logic [phm_pkg::COUNT_W-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
